>>> design/gvs_pkg.sv
// types and constants shared by the gas valve sequencer
// step codes, request codes, status codes, register indexes, channel state record
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gvs_pkg;

  typedef enum logic [6:0] {
    STEP_IDLE     = 7'b0000001,
    STEP_START    = 7'b0000010,
    STEP_SWAIT    = 7'b0000100,
    STEP_RUN      = 7'b0001000,
    STEP_STOP     = 7'b0010000,
    STEP_TWAIT    = 7'b0100000,
    STEP_DISABLED = 7'b1000000
  } step_t;

  typedef enum logic [2:0] {
    REQ_NONE    = 3'd0,
    REQ_START   = 3'd1,
    REQ_STOP    = 3'd2,
    REQ_HALT    = 3'd3,
    REQ_RESTART = 3'd4,
    REQ_FORCE   = 3'd5
  } req_t;

  localparam logic [1:0] STAT_STOPPED  = 2'd0;
  localparam logic [1:0] STAT_STARTDLY = 2'd1;
  localparam logic [1:0] STAT_RUN      = 2'd2;
  localparam logic [1:0] STAT_STOPDLY  = 2'd3;

  localparam logic [1:0] REG_START_DELAY  = 2'd0;
  localparam logic [1:0] REG_STOP_DELAY   = 2'd1;
  localparam logic [1:0] REG_FLOW_TIMEOUT = 2'd2;

  localparam int CFG_W = 16;

  typedef struct packed {
    step_t       step;
    logic        valve;
    logic [1:0]  status;
    logic [15:0] dly;
    logic [15:0] tcnt;
    logic        trun;
    logic        tarm;
    logic        tnz;
  } chan_state_t;

  localparam chan_state_t CHAN_RESET = '{
    step:   STEP_IDLE,
    valve:  1'b0,
    status: STAT_STOPPED,
    dly:    16'd0,
    tcnt:   16'd0,
    trun:   1'b0,
    tarm:   1'b0,
    tnz:    1'b0
  };

  typedef struct packed {
    logic [15:0] start_dly;
    logic [15:0] stop_dly;
    logic [15:0] flow_tmo;
  } cfg_t;

  typedef struct packed {
    logic [2:0] req;
    logic       dis;
    logic       fitted;
    logic       flow;
  } tick_in_t;

  typedef struct packed {
    logic       timeout_error;
    logic [1:0] status;
    logic       valve_on;
  } result_t;

endpackage

`default_nettype wire

>>> design/gvs_chan_step.sv
// one scan tick of one ready channel: command, step machine and flow supervisor
// combinational; uses gvs_pkg
`timescale 1ns / 1ps
`default_nettype none

module gvs_chan_step (
  input  gvs_pkg::chan_state_t cur,
  input  gvs_pkg::tick_in_t    tick,
  input  gvs_pkg::cfg_t        cfg,
  output gvs_pkg::chan_state_t nxt,
  output gvs_pkg::result_t     res
);

  always_comb begin
    gvs_pkg::step_t st;
    logic           sw;
    logic           active;
    logic           err;
    nxt    = cur;
    err    = 1'b0;
    sw     = tick.fitted ? tick.flow : cur.valve;
    st     = cur.step;
    active = (st == gvs_pkg::STEP_START) || (st == gvs_pkg::STEP_SWAIT) ||
             (st == gvs_pkg::STEP_RUN);

    if (tick.dis) begin
      st        = gvs_pkg::STEP_DISABLED;
      nxt.valve = 1'b0;
      if (tick.req inside {gvs_pkg::REQ_FORCE, gvs_pkg::REQ_START}) begin
        nxt.status = gvs_pkg::STAT_RUN;
      end else if (tick.req inside {gvs_pkg::REQ_HALT, gvs_pkg::REQ_RESTART,
                                    gvs_pkg::REQ_STOP}) begin
        nxt.status = gvs_pkg::STAT_STOPPED;
      end else if (cur.status != gvs_pkg::STAT_STOPPED &&
                   cur.status != gvs_pkg::STAT_RUN) begin
        nxt.status = gvs_pkg::STAT_STOPPED;
      end
    end else begin
      case (tick.req)
        gvs_pkg::REQ_HALT, gvs_pkg::REQ_RESTART: begin
          st = gvs_pkg::STEP_IDLE;
        end
        gvs_pkg::REQ_START: begin
          if (!active) st = gvs_pkg::STEP_START;
        end
        gvs_pkg::REQ_STOP: begin
          if (active) st = gvs_pkg::STEP_STOP;
        end
        gvs_pkg::REQ_FORCE: begin
          st = gvs_pkg::STEP_RUN;
        end
        default: begin
        end
      endcase
    end

    case (st)
      gvs_pkg::STEP_IDLE: begin
        nxt.valve  = 1'b0;
        nxt.status = gvs_pkg::STAT_STOPPED;
      end
      gvs_pkg::STEP_START: begin
        nxt.status = gvs_pkg::STAT_STARTDLY;
        nxt.valve  = 1'b1;
        if (cfg.start_dly != 16'd0) begin
          nxt.dly = cfg.start_dly;
          st      = gvs_pkg::STEP_SWAIT;
        end else begin
          st = gvs_pkg::STEP_RUN;
        end
      end
      gvs_pkg::STEP_SWAIT: begin
        nxt.valve = 1'b1;
        if (cur.dly == 16'd0) st = gvs_pkg::STEP_RUN;
      end
      gvs_pkg::STEP_RUN: begin
        nxt.valve  = 1'b1;
        nxt.status = gvs_pkg::STAT_RUN;
      end
      gvs_pkg::STEP_STOP: begin
        nxt.valve  = 1'b1;
        nxt.status = gvs_pkg::STAT_STOPDLY;
        if (cfg.stop_dly != 16'd0) begin
          nxt.dly = cfg.stop_dly;
          st      = gvs_pkg::STEP_TWAIT;
        end else begin
          st = gvs_pkg::STEP_IDLE;
        end
      end
      gvs_pkg::STEP_TWAIT: begin
        nxt.valve = 1'b1;
        if (cur.dly == 16'd0) st = gvs_pkg::STEP_IDLE;
      end
      default: begin
      end
    endcase
    if (nxt.dly != 16'd0) nxt.dly = nxt.dly - 16'd1;

    // flow supervisor works on the valve drive just decided
    if (cur.trun && cur.tcnt == 16'd0) begin
      nxt.trun = 1'b0;
      if (cur.tnz) begin
        err = 1'b1;
        st  = gvs_pkg::STEP_IDLE;
      end
    end else if (!sw && nxt.valve && !cur.tarm) begin
      nxt.tcnt = cfg.flow_tmo;
      nxt.tnz  = (cfg.flow_tmo != 16'd0);
      nxt.trun = 1'b1;
      nxt.tarm = 1'b1;
    end else if (sw || !nxt.valve) begin
      nxt.trun = 1'b0;
      nxt.tarm = 1'b0;
    end
    if (nxt.trun && nxt.tcnt != 16'd0) nxt.tcnt = nxt.tcnt - 16'd1;

    nxt.step          = st;
    res.valve_on      = nxt.valve;
    res.status        = nxt.status;
    res.timeout_error = err;
  end

endmodule

`default_nettype wire

>>> design/gas_valve_sequencer_unit.sv
// top level of the gas valve sequencer: stream ports, tick registers, channel state
// uses gvs_pkg and gvs_chan_step
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction is one scan tick for one valve channel; it yields exactly one
// result transaction. The unit takes one transaction per clock unless the output is stalled;
// a result passes through the input register, then the result register. Channel state is read,
// updated and written back while the tick is in the input register, at the same edge the
// result is registered, so ticks for the same channel may follow each other directly. Ticks
// for a channel at or above NUM_CHANNELS give an all-zero result. The user must write the
// delay and timeout registers via cfg while no tick is in flight; the block does not check.
module gas_valve_sequencer_unit #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire  [1:0]                 cfg_addr,
  input  wire  [gvs_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire                        s_tvalid,
  output logic                       s_tready,
  // channel[1:0], req_type[4:2], disable_req[5], config_ready[6], sensor_fitted[7],
  // flow_switch[8], zero fill [15:9]
  input  wire  [15:0]                s_tdata,
  output logic                       m_tvalid,
  input  wire                        m_tready,
  // valve_on[0], status[2:1], timeout_error[3], zero fill [7:4]
  output logic [7:0]                 m_tdata
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  gvs_pkg::cfg_t        cfg;
  gvs_pkg::chan_state_t ch_state [NUM_CHANNELS];

  logic                 s1_valid;
  logic [1:0]           s1_channel;
  gvs_pkg::tick_in_t    s1_tick;
  logic                 s1_ready_bit;
  logic                 s1_adv;

  logic [IDX_W+1:0]     ch_ext;
  logic [IDX_W-1:0]     idx;
  logic                 in_range;
  gvs_pkg::chan_state_t cur;
  gvs_pkg::chan_state_t nxt;
  gvs_pkg::result_t     res;
  gvs_pkg::result_t     res_sel;

  // tick registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        gvs_pkg::REG_START_DELAY:  cfg.start_dly <= cfg_wdata;
        gvs_pkg::REG_STOP_DELAY:   cfg.stop_dly  <= cfg_wdata;
        gvs_pkg::REG_FLOW_TIMEOUT: cfg.flow_tmo  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_channel     <= s_tdata[1:0];
      s1_tick.req    <= s_tdata[4:2];
      s1_tick.dis    <= s_tdata[5];
      s1_ready_bit   <= s_tdata[6];
      s1_tick.fitted <= s_tdata[7];
      s1_tick.flow   <= s_tdata[8];
    end
  end

  assign ch_ext   = {{IDX_W{1'b0}}, s1_channel};
  assign idx      = ch_ext[IDX_W-1:0];
  assign in_range = (ch_ext < (IDX_W+2)'(NUM_CHANNELS));
  assign cur      = ch_state[idx];

  gvs_chan_step u_step (
    .cur  (cur),
    .tick (s1_tick),
    .cfg  (cfg),
    .nxt  (nxt),
    .res  (res)
  );

  always_comb begin
    res_sel = '0;
    if (in_range) begin
      if (s1_ready_bit) begin
        res_sel = res;
      end else begin
        res_sel.valve_on = cur.valve;
        res_sel.status   = cur.status;
      end
    end
  end

  // channel state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ch_state[i] <= gvs_pkg::CHAN_RESET;
      end
    end else if (s1_adv && in_range && s1_ready_bit) begin
      ch_state[idx] <= nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {4'b0000, res_sel};
    end
  end

  a_reset_empty : assert property (@(posedge clk) rst |=> (!m_tvalid && !s1_valid))
    else $error("pipeline not empty after reset");

  a_out_of_range_zero : assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !in_range) |=> (m_tvalid && m_tdata == 8'd0))
    else $error("out of range channel gave a nonzero result");

  a_not_ready_holds : assert property (@(posedge clk) disable iff (rst)
    (s1_adv && in_range && !s1_ready_bit) |=> (ch_state[$past(idx)] == $past(cur)))
    else $error("channel state changed on a tick with config not ready");

endmodule

`default_nettype wire

>>> tb/sv/tb_gas_valve_sequencer_unit.sv
// self-checking bench for gas_valve_sequencer_unit: directed ticks, then random
// phases of scan ticks under several delay/timeout settings, checked per channel
// depends on gvs_pkg and the unit's rtl
`timescale 1ns / 1ps

module tb_gas_valve_sequencer_unit;

  localparam int NCH = 4;
  localparam int unsigned WDOG_LIMIT = 2000;
  localparam int unsigned TICKS_PER_PHASE = 175;
  localparam int NPHASE = 6;
  // request codes the block has no meaning for
  localparam logic [2:0] REQ_BAD6 = 3'd6;
  localparam logic [2:0] REQ_BAD7 = 3'd7;

  // predicts each channel's valve, status and flow-timeout outcome per scan tick
  class valve_scoreboard;
    logic [15:0]      start_dly, stop_dly, flow_tmo;
    gvs_pkg::step_t   step [NCH];
    logic             valve [NCH];
    logic [1:0]       status [NCH];
    logic [15:0]      dly [NCH];
    logic [15:0]      tcnt [NCH];
    logic             trun [NCH];
    logic             tarm [NCH];
    logic             tnz [NCH];
    gvs_pkg::result_t results_due[$];
    int unsigned      ticks, results, fails, trips, disables;

    function new();
      start_dly = '0;
      stop_dly = '0;
      flow_tmo = '0;
      for (int i = 0; i < NCH; i++) begin
        step[i] = gvs_pkg::STEP_IDLE;
        valve[i] = 1'b0;
        status[i] = gvs_pkg::STAT_STOPPED;
        dly[i] = '0;
        tcnt[i] = '0;
        trun[i] = 1'b0;
        tarm[i] = 1'b0;
        tnz[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        gvs_pkg::REG_START_DELAY:  start_dly = v;
        gvs_pkg::REG_STOP_DELAY:   stop_dly = v;
        gvs_pkg::REG_FLOW_TIMEOUT: flow_tmo = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void note_tick(logic [15:0] d);
      logic [1:0]       ch;
      logic [2:0]       req;
      logic             dis, rdy, fit, flow, sw, active, err;
      gvs_pkg::step_t   st;
      gvs_pkg::result_t r;
      ch = d[1:0];
      req = d[4:2];
      dis = d[5];
      rdy = d[6];
      fit = d[7];
      flow = d[8];
      err = 1'b0;
      ticks++;
      if (!rdy) begin
        r.valve_on = valve[ch];
        r.status = status[ch];
        r.timeout_error = 1'b0;
        results_due.push_back(r);
        return;
      end
      // without a flow switch the previous valve drive stands in for flow
      sw = fit ? flow : valve[ch];
      st = step[ch];
      if (dis) begin
        disables++;
        st = gvs_pkg::STEP_DISABLED;
        valve[ch] = 1'b0;
        if (req == gvs_pkg::REQ_FORCE || req == gvs_pkg::REQ_START)
          status[ch] = gvs_pkg::STAT_RUN;
        else if (req == gvs_pkg::REQ_HALT || req == gvs_pkg::REQ_RESTART ||
                 req == gvs_pkg::REQ_STOP)
          status[ch] = gvs_pkg::STAT_STOPPED;
        else if (status[ch] != gvs_pkg::STAT_STOPPED && status[ch] != gvs_pkg::STAT_RUN)
          status[ch] = gvs_pkg::STAT_STOPPED;
      end else begin
        active = (st == gvs_pkg::STEP_START || st == gvs_pkg::STEP_SWAIT ||
                  st == gvs_pkg::STEP_RUN);
        if (req == gvs_pkg::REQ_HALT || req == gvs_pkg::REQ_RESTART) st = gvs_pkg::STEP_IDLE;
        else if (req == gvs_pkg::REQ_START) begin
          if (!active) st = gvs_pkg::STEP_START;
        end else if (req == gvs_pkg::REQ_STOP) begin
          if (active) st = gvs_pkg::STEP_STOP;
        end else if (req == gvs_pkg::REQ_FORCE) st = gvs_pkg::STEP_RUN;
      end

      case (st)
        gvs_pkg::STEP_IDLE: begin
          valve[ch] = 1'b0;
          status[ch] = gvs_pkg::STAT_STOPPED;
        end
        gvs_pkg::STEP_START: begin
          status[ch] = gvs_pkg::STAT_STARTDLY;
          valve[ch] = 1'b1;
          if (start_dly > 0) begin
            dly[ch] = start_dly;
            st = gvs_pkg::STEP_SWAIT;
          end else st = gvs_pkg::STEP_RUN;
        end
        gvs_pkg::STEP_SWAIT: begin
          valve[ch] = 1'b1;
          if (dly[ch] == 0) st = gvs_pkg::STEP_RUN;
        end
        gvs_pkg::STEP_RUN: begin
          valve[ch] = 1'b1;
          status[ch] = gvs_pkg::STAT_RUN;
        end
        gvs_pkg::STEP_STOP: begin
          valve[ch] = 1'b1;
          status[ch] = gvs_pkg::STAT_STOPDLY;
          if (stop_dly > 0) begin
            dly[ch] = stop_dly;
            st = gvs_pkg::STEP_TWAIT;
          end else st = gvs_pkg::STEP_IDLE;
        end
        gvs_pkg::STEP_TWAIT: begin
          valve[ch] = 1'b1;
          if (dly[ch] == 0) st = gvs_pkg::STEP_IDLE;
        end
        default: ;
      endcase
      if (dly[ch] > 0) dly[ch]--;

      // flow supervisor: armed once per no-flow episode, fires when it reads zero
      if (trun[ch] && tcnt[ch] == 0) begin
        trun[ch] = 1'b0;
        if (tnz[ch]) begin
          err = 1'b1;
          st = gvs_pkg::STEP_IDLE;
          trips++;
        end
      end else if (!sw && valve[ch] && !tarm[ch]) begin
        tcnt[ch] = flow_tmo;
        tnz[ch] = (flow_tmo != 0);
        trun[ch] = 1'b1;
        tarm[ch] = 1'b1;
      end else if (sw || !valve[ch]) begin
        trun[ch] = 1'b0;
        tarm[ch] = 1'b0;
      end
      if (trun[ch] && tcnt[ch] > 0) tcnt[ch]--;

      step[ch] = st;
      r.valve_on = valve[ch];
      r.status = status[ch];
      r.timeout_error = err;
      results_due.push_back(r);
    endfunction

    function void note_mismatch(string what, logic [3:0] want, logic [3:0] got);
      fails++;
      if (fails <= 10)
        $display("%0t: mismatch on %s at result %0d: expected %h, got %h",
                 $time, what, results, want, got);
    endfunction

    function void check_result(logic [7:0] d);
      gvs_pkg::result_t got, want;
      got = gvs_pkg::result_t'(d[3:0]);
      results++;
      if (results_due.size() == 0) begin
        note_mismatch("unexpected transaction", 4'h0, d[3:0]);
        return;
      end
      want = results_due.pop_front();
      if (got.valve_on !== want.valve_on)
        note_mismatch("valve_on", 4'(want.valve_on), 4'(got.valve_on));
      if (got.status !== want.status)
        note_mismatch("status", 4'(want.status), 4'(got.status));
      if (got.timeout_error !== want.timeout_error)
        note_mismatch("timeout_error", 4'(want.timeout_error), 4'(got.timeout_error));
      if (d[7:4] !== 4'h0) note_mismatch("zero fill", 4'h0, d[7:4]);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [7:0]  m_tdata;

  valve_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned rdy_hold = 0;
  int unsigned n_settings = 0;
  bit          quiet = 1'b1;
  bit          tx_hot = 1'b0;
  bit          flow_ok [NCH];
  bit          fit_on [NCH];

  gas_valve_sequencer_unit #(.NUM_CHANNELS(NCH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pack_tick(logic [1:0] ch, logic [2:0] req, logic dis,
                                            logic rdy, logic fit, logic flow);
    return {7'd0, flow, fit, rdy, dis, req, ch};
  endfunction

  // per-channel flow and sensor levels drift slowly so timeouts can build up
  function automatic logic [15:0] rand_tick();
    logic [1:0]  ch;
    logic [2:0]  req;
    int unsigned r;
    ch = 2'($urandom_range(0, NCH - 1));
    if ($urandom_range(0, 99) < 8) flow_ok[ch] = !flow_ok[ch];
    if ($urandom_range(0, 99) < 3) fit_on[ch] = !fit_on[ch];
    r = $urandom_range(0, 99);
    if (r < 55) req = gvs_pkg::REQ_NONE;
    else if (r < 67) req = gvs_pkg::REQ_START;
    else if (r < 77) req = gvs_pkg::REQ_STOP;
    else if (r < 81) req = gvs_pkg::REQ_HALT;
    else if (r < 84) req = gvs_pkg::REQ_RESTART;
    else if (r < 89) req = gvs_pkg::REQ_FORCE;
    else if (r < 91) req = REQ_BAD6;
    else if (r < 93) req = REQ_BAD7;
    else req = gvs_pkg::REQ_NONE;
    return pack_tick(ch, req, $urandom_range(0, 99) < 4, $urandom_range(0, 99) < 92,
                     fit_on[ch], flow_ok[ch]);
  endfunction

  // receiver side: random stalls unless in a quiet stretch
  always @(posedge clk) begin
    if (!m_tready) begin
      if (rdy_hold == 0) m_tready <= 1'b1;
      else rdy_hold <= rdy_hold - 1;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      m_tready <= 1'b0;
      rdy_hold <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_tick(s_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WDOG_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, WDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  task automatic push_tick(input logic [15:0] d, input int unsigned gap);
    s_tdata <= d;
    if (!tx_hot) s_tvalid <= 1'b1;
    tx_hot = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      tx_hot = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_settled();
    if (tx_hot) begin
      s_tvalid <= 1'b0;
      tx_hot = 1'b0;
    end
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_tick_regs(input logic [15:0] sdly, input logic [15:0] tdly,
                                input logic [15:0] tmo);
    cfg_we <= 1'b1;
    cfg_addr <= gvs_pkg::REG_START_DELAY;
    cfg_wdata <= sdly;
    @(posedge clk);
    cfg_addr <= gvs_pkg::REG_STOP_DELAY;
    cfg_wdata <= tdly;
    @(posedge clk);
    cfg_addr <= gvs_pkg::REG_FLOW_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(gvs_pkg::REG_START_DELAY, sdly);
    sb.set_reg(gvs_pkg::REG_STOP_DELAY, tdly);
    sb.set_reg(gvs_pkg::REG_FLOW_TIMEOUT, tmo);
    n_settings++;
  endtask

  initial begin
    for (int i = 0; i < NCH; i++) begin
      flow_ok[i] = 1'b1;
      fit_on[i] = 1'b1;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_tick_regs(16'd2, 16'd1, 16'd2);

    // fields: channel, request, disable, ready, sensor fitted, flow
    // normal start through run and stop delay back to idle
    push_tick(pack_tick(2'd0, gvs_pkg::REQ_START, 1'b0, 1'b1, 1'b1, 1'b1), 0);
    repeat (3) push_tick(pack_tick(2'd0, gvs_pkg::REQ_NONE, 1'b0, 1'b1, 1'b1, 1'b1), 0);
    push_tick(pack_tick(2'd0, gvs_pkg::REQ_STOP, 1'b0, 1'b1, 1'b1, 1'b1), 0);
    repeat (2) push_tick(pack_tick(2'd0, gvs_pkg::REQ_NONE, 1'b0, 1'b1, 1'b1, 1'b1), 0);
    // forced on with no flow until the timeout trips
    push_tick(pack_tick(2'd1, gvs_pkg::REQ_FORCE, 1'b0, 1'b1, 1'b1, 1'b0), 0);
    repeat (3) push_tick(pack_tick(2'd1, gvs_pkg::REQ_NONE, 1'b0, 1'b1, 1'b1, 1'b0), 0);
    // disable override with various requests, then leaving disable
    push_tick(pack_tick(2'd2, gvs_pkg::REQ_START, 1'b1, 1'b1, 1'b1, 1'b1), 0);
    push_tick(pack_tick(2'd2, gvs_pkg::REQ_HALT, 1'b1, 1'b1, 1'b1, 1'b1), 0);
    push_tick(pack_tick(2'd2, gvs_pkg::REQ_FORCE, 1'b1, 1'b1, 1'b1, 1'b1), 0);
    push_tick(pack_tick(2'd2, gvs_pkg::REQ_NONE, 1'b1, 1'b1, 1'b1, 1'b1), 0);
    push_tick(pack_tick(2'd2, gvs_pkg::REQ_STOP, 1'b1, 1'b1, 1'b1, 1'b1), 0);
    push_tick(pack_tick(2'd2, gvs_pkg::REQ_NONE, 1'b0, 1'b1, 1'b1, 1'b1), 0);
    push_tick(pack_tick(2'd2, gvs_pkg::REQ_RESTART, 1'b0, 1'b1, 1'b1, 1'b1), 0);
    // channel not ready, no sensor fitted, unknown requests, halt
    push_tick(pack_tick(2'd3, gvs_pkg::REQ_START, 1'b0, 1'b0, 1'b1, 1'b1), 0);
    push_tick(pack_tick(2'd3, gvs_pkg::REQ_START, 1'b0, 1'b1, 1'b0, 1'b0), 0);
    push_tick(pack_tick(2'd3, REQ_BAD6, 1'b0, 1'b1, 1'b0, 1'b0), 0);
    push_tick(pack_tick(2'd3, REQ_BAD7, 1'b0, 1'b1, 1'b0, 1'b1), 0);
    push_tick(pack_tick(2'd3, gvs_pkg::REQ_HALT, 1'b0, 1'b1, 1'b0, 1'b1), 0);
    wait_settled();

    quiet = 1'b0;
    for (int p = 0; p < NPHASE; p++) begin
      case (p)
        0: load_tick_regs(16'd0, 16'd0, 16'd0);
        1: load_tick_regs(16'd1, 16'd2, 16'd3);
        2: load_tick_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: load_tick_regs(16'd3, 16'd0, 16'd1);
        4: load_tick_regs(16'd0, 16'd5, 16'd4);
        default: load_tick_regs(16'd2, 16'd1, 16'd0);
      endcase
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) quiet = !quiet;
        push_tick(rand_tick(), quiet ? 0 : gap_len());
        // sender holds off until everything in flight has come back
        if ($urandom_range(0, 199) == 0) wait_settled();
      end
      wait_settled();
    end

    $display("ran %0d scan ticks, %0d results checked, over %0d register settings",
             sb.ticks, sb.results, n_settings);
    $display("flow timeouts tripped: %0d, ticks under disable: %0d, mismatches: %0d",
             sb.trips, sb.disables, sb.fails);
    if (sb.fails == 0 && sb.pending() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
design/gvs_pkg.sv
design/gvs_chan_step.sv
design/gas_valve_sequencer_unit.sv
tb/sv/tb_gas_valve_sequencer_unit.sv
